### src/rgb2lab_pkg.sv
// shared types, constants and elaboration-time functions for the srgb to cielab converter
// no dependencies
package rgb2lab_pkg;

  typedef logic [16:0] q16_t;

  // cube root unit: input register plus one stage per result bit
  localparam int CBRT_BITS = 17;
  localparam int CBRT_LAT  = CBRT_BITS + 1;

  // companding linear branch: t <= threshold
  localparam int          CMP_THRESH = (8856 * 65536) / 1000000;
  localparam logic [19:0] CMP_SLOPE  = 20'd903292;
  localparam logic [30:0] CMP_OFFS   = 31'd1048634000;
  localparam int          CMP_SHIFT  = 48;
  localparam logic [31:0] CMP_RECIP  = 32'(((64'd1 << CMP_SHIFT) + 64'd115999) / 64'd116000);

  // srgb to xyz matrix, units of 1/10000
  localparam logic [13:0] M_XR = 14'd4124;
  localparam logic [13:0] M_XG = 14'd3576;
  localparam logic [13:0] M_XB = 14'd1805;
  localparam logic [13:0] M_YR = 14'd2126;
  localparam logic [13:0] M_YG = 14'd7152;
  localparam logic [13:0] M_YB = 14'd722;
  localparam logic [13:0] M_ZR = 14'd193;
  localparam logic [13:0] M_ZG = 14'd1192;
  localparam logic [13:0] M_ZB = 14'd9505;

  // white point division by reciprocal, exact for numerators below 2^30
  localparam int          WP_SHIFT = 44;
  localparam logic [29:0] WP_X_HALF = 30'd4752;
  localparam logic [29:0] WP_Y_HALF = 30'd5000;
  localparam logic [29:0] WP_Z_HALF = 30'd5445;
  localparam logic [30:0] WP_X_RECIP = 31'(((64'd1 << WP_SHIFT) + 64'd9504) / 64'd9505);
  localparam logic [30:0] WP_Y_RECIP = 31'(((64'd1 << WP_SHIFT) + 64'd9999) / 64'd10000);
  localparam logic [30:0] WP_Z_RECIP = 31'(((64'd1 << WP_SHIFT) + 64'd10889) / 64'd10890);

  // srgb gamma removal of one code, q16, evaluated while building the table
  // t_pow is the q30 base of the power segment, v_lin the q16 linear segment value
  function automatic q16_t lin_from_code(input longint unsigned c, input longint unsigned m,
                                         input longint unsigned t_pow,
                                         input longint unsigned v_lin);
    longint unsigned t;
    longint unsigned s;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned p;
    longint unsigned v;
    if (c * 100000 > 4045 * m) begin
      t  = t_pow;
      s  = (t * t) >> 30;
      lo = 0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        p = mid;
        for (int k = 0; k < 4; k++) begin
          p = (p * mid) >> 30;
        end
        if (p <= s) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      v = (((s * lo) >> 30) + (64'd1 << 13)) >> 14;
    end else begin
      v = v_lin;
    end
    return q16_t'(v);
  endfunction

endpackage

### src/rgb2lab_cbrt.sv
// lab companding of one normalized q16 channel: pipelined cube root, one result bit per stage,
// with the linear branch alongside; uses rgb2lab_pkg
module rgb2lab_cbrt (
  input  logic                clk,
  input  logic                en,
  input  rgb2lab_pkg::q16_t   t_i,
  output rgb2lab_pkg::q16_t   f_o
);
  import rgb2lab_pkg::*;

  logic [16:0] t_r    [CBRT_BITS+1];
  logic        cube_r [CBRT_BITS+1];
  logic [16:0] lo_r   [CBRT_BITS+1];
  logic [33:0] lo2_r  [CBRT_BITS+1];
  logic [50:0] lo3_r  [CBRT_BITS+1];
  logic [16:0] flin_r [CBRT_BITS+1];
  logic [30:0] num_r;
  logic [62:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0]    <= t_i;
      cube_r[0] <= (t_i > 17'(CMP_THRESH));
      lo_r[0]   <= '0;
      lo2_r[0]  <= '0;
      lo3_r[0]  <= '0;
      flin_r[0] <= '0;
      num_r     <= 31'(CMP_SLOPE * t_i[9:0]) + CMP_OFFS;
      prod_r    <= 63'(num_r * CMP_RECIP);
    end
  end

  for (genvar j = 1; j <= CBRT_BITS; j++) begin : g_dig
    localparam int K = CBRT_BITS - j;
    logic [33:0] cand2;
    logic [50:0] cand3;
    logic [50:0] lo2x3;
    logic [50:0] lox3;
    assign lo2x3 = ({17'b0, lo2_r[j-1]} << 1) + {17'b0, lo2_r[j-1]};
    assign lox3  = ({34'b0, lo_r[j-1]} << 1) + {34'b0, lo_r[j-1]};
    assign cand2 = lo2_r[j-1] + ({17'b0, lo_r[j-1]} << (K + 1)) + (34'd1 << (2 * K));
    assign cand3 = lo3_r[j-1] + (lo2x3 << K) + (lox3 << (2 * K)) + (51'd1 << (3 * K));

    always_ff @(posedge clk) begin
      if (en) begin
        t_r[j]    <= t_r[j-1];
        cube_r[j] <= cube_r[j-1];
        if (cand3 <= {2'b0, t_r[j-1], 32'b0}) begin
          lo_r[j]  <= lo_r[j-1] | (17'd1 << K);
          lo2_r[j] <= cand2;
          lo3_r[j] <= cand3;
        end else begin
          lo_r[j]  <= lo_r[j-1];
          lo2_r[j] <= lo2_r[j-1];
          lo3_r[j] <= lo3_r[j-1];
        end
        if (j == 2) begin
          flin_r[j] <= {2'b0, prod_r[CMP_SHIFT+14:CMP_SHIFT]};
        end else begin
          flin_r[j] <= flin_r[j-1];
        end
      end
    end
  end

  assign f_o = cube_r[CBRT_BITS] ? lo_r[CBRT_BITS] : flin_r[CBRT_BITS];

endmodule

### src/rgb_to_lab_converter.sv
// srgb to cielab (d65) pixel converter, fully pipelined, one pixel per clock
// depends on rgb2lab_pkg and rgb2lab_cbrt
//
//   channel | ports                      | payload
//   --------+----------------------------+------------------------------------------
//   input   | in_tvalid/in_tready/tdata  | red, green, blue codes
//   result  | out_tvalid/out_tready/tdata| lightness_l q7.8, chroma_a, chroma_b q8.8
//
// one item per cycle; stages from acceptance to out_tvalid: gamma table, matrix,
// white point reciprocal, 18-stage cube root unit, scale, round and clamp
// all stages advance together; a stalled output holds the whole pipeline
// rst_n clears only the valid bits; in_tready is low while in reset
module rgb_to_lab_converter #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // red, green, blue (CHANNEL_BITS each), zero pad
  input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // lightness_l [14:0], chroma_a [30:15], chroma_b [46:31], zero pad
  output logic [47:0]                            out_tdata
);
  import rgb2lab_pkg::*;

  localparam int CODES = 1 << CHANNEL_BITS;
  localparam int LAT   = 5 + CBRT_LAT;
  localparam longint unsigned CODE_M = longint'(CODES - 1);

  logic [LAT-1:0] v_r;
  logic           en;

  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  q16_t lin_lut [CODES];
  q16_t rl_r, gl_r, bl_r;
  logic [29:0] xs_r, ys_r, zs_r;
  logic [60:0] px_r, py_r, pz_r;
  q16_t fx, fy, fz;
  logic signed [27:0] lm_r, am_r, bm_r;
  logic signed [27:0] lr, ar, br;
  logic [14:0] l_nxt;
  logic [15:0] a_nxt, b_nxt;
  logic [14:0] l_r;
  logic [15:0] a_r, b_r;
  logic signed [17:0] dxy, dyz;

  function automatic logic signed [27:0] round_q8(input logic signed [27:0] v);
    logic [27:0] mag;
    logic [27:0] r;
    mag = v[27] ? 28'(-v) : 28'(v);
    r   = (mag + 28'd128) >> 8;
    return v[27] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [27:0] v);
    logic [15:0] r;
    if (v > 28'sd32767) begin
      r = 16'h7fff;
    end else if (v < -28'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign en        = out_tready | ~v_r[LAT-1];
  assign in_tready = en & rst_n;

  assign red   = in_tdata[CHANNEL_BITS-1:0];
  assign green = in_tdata[2*CHANNEL_BITS-1:CHANNEL_BITS];
  assign blue  = in_tdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS];

  for (genvar i = 0; i < CODES; i++) begin : g_lut
    localparam longint unsigned TP =
      ((1000 * longint'(i) + 55 * CODE_M) << 30) / (1055 * CODE_M);
    localparam longint unsigned VL =
      (longint'(i) * 6553600 + 646 * CODE_M) / (1292 * CODE_M);
    localparam q16_t LV = lin_from_code(longint'(i), CODE_M, TP, VL);
    assign lin_lut[i] = LV;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rl_r <= lin_lut[red];
      gl_r <= lin_lut[green];
      bl_r <= lin_lut[blue];
      xs_r <= M_XR * rl_r + M_XG * gl_r + M_XB * bl_r + WP_X_HALF;
      ys_r <= M_YR * rl_r + M_YG * gl_r + M_YB * bl_r + WP_Y_HALF;
      zs_r <= M_ZR * rl_r + M_ZG * gl_r + M_ZB * bl_r + WP_Z_HALF;
      px_r <= xs_r * WP_X_RECIP;
      py_r <= ys_r * WP_Y_RECIP;
      pz_r <= zs_r * WP_Z_RECIP;
    end
  end

  rgb2lab_cbrt u_cbrt_x (.clk(clk), .en(en), .t_i(px_r[WP_SHIFT+16:WP_SHIFT]), .f_o(fx));
  rgb2lab_cbrt u_cbrt_y (.clk(clk), .en(en), .t_i(py_r[WP_SHIFT+16:WP_SHIFT]), .f_o(fy));
  rgb2lab_cbrt u_cbrt_z (.clk(clk), .en(en), .t_i(pz_r[WP_SHIFT+16:WP_SHIFT]), .f_o(fz));

  assign dxy = $signed({1'b0, fx}) - $signed({1'b0, fy});
  assign dyz = $signed({1'b0, fy}) - $signed({1'b0, fz});

  always_ff @(posedge clk) begin
    if (en) begin
      lm_r <= $signed({11'b0, fy}) * 28'sd116 - 28'sd1048576;
      am_r <= $signed({{10{dxy[17]}}, dxy}) * 28'sd500;
      bm_r <= $signed({{10{dyz[17]}}, dyz}) * 28'sd200;
    end
  end

  always_comb begin
    lr = round_q8(lm_r);
    ar = round_q8(am_r);
    br = round_q8(bm_r);
    if (lr < 28'sd0) begin
      l_nxt = '0;
    end else if (lr > 28'sd25600) begin
      l_nxt = 15'd25600;
    end else begin
      l_nxt = lr[14:0];
    end
    a_nxt = sat16(ar);
    b_nxt = sat16(br);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_r <= l_nxt;
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  assign out_tvalid = v_r[LAT-1];
  assign out_tdata  = {1'b0, b_r, a_r, l_r};

endmodule

### test/tb_top.sv
// testbench for rgb_to_lab_converter: random and directed pixels, checked against a local model
// depends on rgb_to_lab_converter and rgb2lab_pkg (through the block only)
module tb_top;

  localparam int CB = 8;
  localparam int IN_W = ((3*CB+7)/8)*8;
  localparam int WATCHDOG = 5000;

  typedef struct packed {
    logic [14:0] lightness_l;
    logic [15:0] chroma_a;
    logic [15:0] chroma_b;
  } lab_t;

  function automatic longint unsigned gamma_lin(longint unsigned c);
    longint unsigned m, t, s, lo, hi, mid, p;
    m = (64'd1 << CB) - 1;
    if (c * 100000 > 4045 * m) begin
      t = ((1000 * c + 55 * m) << 30) / (1055 * m);
      s = (t * t) >> 30;
      lo = 0;
      hi = 64'd1 << 30;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        p = mid;
        for (int k = 0; k < 4; k++) p = (p * mid) >> 30;
        if (p <= s) lo = mid;
        else hi = mid - 1;
      end
      return (((s * lo) >> 30) + (64'd1 << 13)) >> 14;
    end
    return (c * 6553600 + 646 * m) / (1292 * m);
  endfunction

  function automatic longint lab_f(longint unsigned t);
    longint unsigned n, lo, hi, mid;
    if (t * 1000000 > 8856 * 65536) begin
      n = t << 32;
      lo = 0;
      hi = (64'd1 << 17) - 1;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        if (mid * mid * mid <= n) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    end
    return (7787 * 116 * t + 16 * 65536000 + 58000) / 116000;
  endfunction

  function automatic longint rnd256(longint n);
    if (n >= 0) return (n + 128) / 256;
    return -((-n + 128) / 256);
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic lab_t pixel_to_lab(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint unsigned rl, gl, bl;
    longint fx, fy, fz, l, a, bb;
    lab_t res;
    rl = gamma_lin(r);
    gl = gamma_lin(g);
    bl = gamma_lin(b);
    fx = lab_f((4124 * rl + 3576 * gl + 1805 * bl + 4752) / 9505);
    fy = lab_f((2126 * rl + 7152 * gl + 722 * bl + 5000) / 10000);
    fz = lab_f((193 * rl + 1192 * gl + 9505 * bl + 5445) / 10890);
    l = sat(rnd256(116 * fy - 16 * 65536), 0, 25600);
    a = sat(rnd256(500 * (fx - fy)), -32768, 32767);
    bb = sat(rnd256(200 * (fy - fz)), -32768, 32767);
    res.lightness_l = l[14:0];
    res.chroma_a = a[15:0];
    res.chroma_b = bb[15:0];
    return res;
  endfunction

  class lab_scoreboard;
    lab_t pending[$];
    int errors = 0;

    function void note_pixel(logic [IN_W-1:0] d);
      pending.push_back(pixel_to_lab(d[7:0], d[15:8], d[23:16]));
    endfunction

    function void check_lab(logic [47:0] d);
      lab_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[14:0] !== e.lightness_l || d[30:15] !== e.chroma_a ||
          d[46:31] !== e.chroma_b) begin
        errors++;
        if (errors <= 10)
          $display("mismatch l %0d/%0d a %0d/%0d b %0d/%0d", e.lightness_l, d[14:0],
                   $signed(e.chroma_a), $signed(d[30:15]),
                   $signed(e.chroma_b), $signed(d[46:31]));
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [47:0] out_tdata;
  logic calm = 0;
  int idle_cycles = 0;
  lab_scoreboard sb;

  rgb_to_lab_converter #(.CHANNEL_BITS(CB)) uut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_pixel(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_lab(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver stalls in random bursts until calm is set
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        out_tready <= 0;
        repeat (n - 1) @(posedge clk);
      end else out_tready <= 1;
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 3);
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {b, g, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    logic [7:0] edges[6];
    edges = '{8'd0, 8'd1, 8'd10, 8'd11, 8'd254, 8'd255};
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_pixel(0, 0, 0);
    send_pixel(255, 255, 255);
    send_pixel(255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, 0, 255);
    send_pixel(255, 0, 255);
    send_pixel(0, 255, 255);
    send_pixel(255, 255, 0);
    send_pixel(10, 10, 10);
    send_pixel(11, 11, 11);
    send_pixel(1, 1, 1);
    for (int i = 0; i < 6; i++) send_pixel(edges[i], edges[5 - i], edges[i]);
    for (int i = 0; i < 1550; i++) begin
      if (i == 1300) calm <= 1;
      if ($urandom_range(0, 4) == 0)
        send_pixel(edges[$urandom_range(0, 5)], edges[$urandom_range(0, 5)],
                   edges[$urandom_range(0, 5)]);
      else send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### rgb_to_lab_converter.f
src/rgb2lab_pkg.sv
src/rgb2lab_cbrt.sv
src/rgb_to_lab_converter.sv
test/tb_top.sv
